FILE: src/sobel_pkg.sv
// Shared types, constants and the Sobel magnitude function for the edge detector.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

    localparam int SOBEL_MAX_WIDTH = 2048;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int WIDTH_BITS      = 12;
    localparam int HEIGHT_BITS     = 13;
    localparam int PIX_BITS        = 8;
    localparam int CFG_DATA_BITS   = 13;
    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;

    localparam logic KIND_FLUSH = 1'b1;
    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'hFF;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [PIX_BITS-1:0] t_pix;
    typedef logic [8:0][PIX_BITS-1:0] t_win;

    typedef struct packed {
        logic produce;
        logic interior;
        logic last;
    } t_pos_info;

    function automatic t_pix sobel_inv(input t_win w);
        logic [9:0]  gx_p;
        logic [9:0]  gx_n;
        logic [9:0]  gy_p;
        logic [9:0]  gy_n;
        logic [9:0]  ax;
        logic [9:0]  ay;
        logic [10:0] mag;
        gx_p = {2'b00, w[2]} + {1'b0, w[5], 1'b0} + {2'b00, w[8]};
        gx_n = {2'b00, w[0]} + {1'b0, w[3], 1'b0} + {2'b00, w[6]};
        gy_p = {2'b00, w[0]} + {1'b0, w[1], 1'b0} + {2'b00, w[2]};
        gy_n = {2'b00, w[6]} + {1'b0, w[7], 1'b0} + {2'b00, w[8]};
        ax   = (gx_p >= gx_n) ? (gx_p - gx_n) : (gx_n - gx_p);
        ay   = (gy_p >= gy_n) ? (gy_p - gy_n) : (gy_n - gy_p);
        mag  = {1'b0, ax} + {1'b0, ay};
        return (mag[10:8] != 3'b000) ? '0 : (PIX_MAX - mag[7:0]);
    endfunction

endpackage

`default_nettype wire

FILE: src/sobel_if.sv
// Valid/ready channel interfaces for pixel input, result output and register writes.
// Depends on sobel_pkg for field widths and the register index type.
`timescale 1ns / 1ps
`default_nettype none

interface sobel_in_if;
    import sobel_pkg::*;
    logic valid;
    logic ready;
    logic kind;
    t_pix pixel;
    modport source (output valid, output kind, output pixel, input ready);
    modport sink (input valid, input kind, input pixel, output ready);
endinterface

interface sobel_out_if;
    import sobel_pkg::*;
    logic valid;
    logic ready;
    t_pix edge_res;
    logic last_of_frame;
    modport source (output valid, output edge_res, output last_of_frame, input ready);
    modport sink (input valid, input edge_res, input last_of_frame, output ready);
endinterface

interface sobel_cfg_if;
    import sobel_pkg::*;
    logic                     valid;
    logic                     ready;
    t_cfg_idx                 index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/sobel_ctrl.sv
// Frame geometry registers, stream position counters and per-item position decode.
// Depends on sobel_pkg and the configuration channel interface.
`timescale 1ns / 1ps
`default_nettype none

module sobel_ctrl import sobel_pkg::*; #(
    parameter int MAX_WIDTH = SOBEL_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sobel_cfg_if.sink        i_cfg,
    input  wire logic        i_accept,
    input  wire logic        i_kind,
    input  wire t_pix        i_pixel,
    output logic [CW-1:0]    o_col,
    output t_pix             o_px,
    output t_pos_info        o_info
);

    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WW-1:0]          r_eff_w;
    logic [HEIGHT_BITS-1:0] r_eff_h;
    logic [CW-1:0]          r_col;
    logic [HEIGHT_BITS-1:0] r_row;
    logic [CW-1:0]          n_col;
    logic [HEIGHT_BITS-1:0] n_row;

    logic [WIDTH_BITS-1:0]  cfg_w;
    logic [HEIGHT_BITS-1:0] cfg_h;
    logic [WW-1:0]          cfg_eff_w;
    logic [HEIGHT_BITS-1:0] cfg_eff_h;
    logic                   cfg_wr;

    logic                   col_nz;
    logic [WW-1:0]          w_m1;
    logic [HEIGHT_BITS-1:0] h_m1;
    logic [CW-1:0]          ox;
    logic [HEIGHT_BITS-1:0] oy;
    t_pos_info              info;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign cfg_w       = i_cfg.data[WIDTH_BITS-1:0];
    assign cfg_h       = i_cfg.data[HEIGHT_BITS-1:0];

    always_comb begin
        if (cfg_w == '0) begin
            cfg_eff_w = WW'(1);
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            cfg_eff_w = WW'(MAX_WIDTH);
        end else begin
            cfg_eff_w = WW'(cfg_w);
        end
        if (cfg_h == '0) begin
            cfg_eff_h = HEIGHT_BITS'(1);
        end else if (32'(cfg_h) > 32'(HEIGHT_LIMIT)) begin
            cfg_eff_h = HEIGHT_BITS'(HEIGHT_LIMIT);
        end else begin
            cfg_eff_h = cfg_h;
        end
    end

    always_comb begin
        col_nz = (r_col != '0);
        w_m1   = r_eff_w - WW'(1);
        h_m1   = r_eff_h - HEIGHT_BITS'(1);
        ox     = col_nz ? (r_col - CW'(1)) : CW'(w_m1);
        oy     = col_nz ? (r_row - HEIGHT_BITS'(1)) : (r_row - HEIGHT_BITS'(2));

        info.produce  = (r_row >= HEIGHT_BITS'(2)) || ((r_row == HEIGHT_BITS'(1)) && col_nz);
        info.last     = (WW'(ox) == w_m1) && (oy == h_m1);
        info.interior = (oy != '0) && (oy < h_m1) && (ox != '0) && (WW'(ox) < w_m1);

        if (info.produce && info.last) begin
            n_col = '0;
            n_row = '0;
        end else if ((WW'(r_col) + WW'(1)) == r_eff_w) begin
            n_col = '0;
            n_row = r_row + HEIGHT_BITS'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= WW'(RST_W);
            r_eff_h <= HEIGHT_BITS'(RESET_HEIGHT);
            r_col   <= '0;
            r_row   <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH: begin
                    r_eff_w <= cfg_eff_w;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_eff_h <= cfg_eff_h;
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col  = r_col;
    assign o_px   = ((i_kind == KIND_FLUSH) || (r_row >= r_eff_h)) ? '0 : i_pixel;
    assign o_info = info;

endmodule

`default_nettype wire

FILE: src/sobel_line_buf.sv
// Two line memories with registered, write-first reads for the previous two lines.
// Depends on sobel_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module sobel_line_buf import sobel_pkg::*; #(
    parameter int MAX_WIDTH = SOBEL_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [CW-1:0] i_rd_col,
    input  wire logic          i_wr_en,
    input  wire logic [CW-1:0] i_wr_col,
    input  wire t_pix          i_wr_px,
    output t_pix               o_mid,
    output t_pix               o_top
);

    t_pix r_store_a [MAX_WIDTH];
    t_pix r_store_b [MAX_WIDTH];
    t_pix r_rd_a;
    t_pix r_rd_b;
    logic same_col;

    assign same_col = i_wr_en && (i_wr_col == i_rd_col);

    // The line one back moves down into the older store as the new pixel replaces it.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store_a[i_wr_col] <= i_wr_px;
            r_store_b[i_wr_col] <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= same_col ? i_wr_px : r_store_a[i_rd_col];
            r_rd_b <= same_col ? r_rd_a  : r_store_b[i_rd_col];
        end
    end

    assign o_mid = r_rd_a;
    assign o_top = r_rd_b;

endmodule

`default_nettype wire

FILE: src/sobel_core.sv
// Item stage, 3x3 window, Sobel magnitude and the result register with its handshake.
// Depends on sobel_pkg and the result channel interface.
`timescale 1ns / 1ps
`default_nettype none

module sobel_core import sobel_pkg::*; #(
    parameter int MAX_WIDTH = SOBEL_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [CW-1:0] i_col,
    input  wire t_pix          i_px,
    input  wire t_pos_info     i_info,
    input  wire t_pix          i_top,
    input  wire t_pix          i_mid,
    output logic               o_in_ready,
    output logic               o_wr_en,
    output logic [CW-1:0]      o_wr_col,
    output t_pix               o_wr_px,
    sobel_out_if.source        o_res
);

    logic          r_a_vld;
    logic [CW-1:0] r_a_col;
    t_pix          r_a_px;
    t_pos_info     r_a_info;
    t_win          r_win;
    t_win          n_win;
    logic          r_out_vld;
    t_pix          r_out_edge;
    logic          r_out_last;
    logic          out_free;
    logic          adv;

    assign out_free   = !r_out_vld || o_res.ready;
    assign adv        = r_a_vld && (!r_a_info.produce || out_free);
    assign o_in_ready = !r_a_vld || adv;

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_win     <= '0;
        end else begin
            if (i_accept) begin
                r_a_vld <= 1'b1;
            end else if (adv) begin
                r_a_vld <= 1'b0;
            end
            if (adv && r_a_info.produce) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (adv) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_col  <= i_col;
            r_a_px   <= i_px;
            r_a_info <= i_info;
        end
        if (adv && r_a_info.produce) begin
            r_out_edge <= r_a_info.interior ? sobel_inv(n_win) : PIX_MAX;
            r_out_last <= r_a_info.last;
        end
    end

    assign o_wr_en             = adv;
    assign o_wr_col            = r_a_col;
    assign o_wr_px             = r_a_px;
    assign o_res.valid         = r_out_vld;
    assign o_res.edge_res      = r_out_edge;
    assign o_res.last_of_frame = r_out_last;

endmodule

`default_nettype wire

FILE: src/sobel_edge_magnitude_inverted.sv
// The item that completes a pixel's window, a line plus one pixel later in the stream,
// goes through the item register, then the result register. Throughput: one item per
// clock unless a result stalls; line memories take one read and one write per cycle.
// Reset: synchronous, active low; clears position counters, handshake state and the window
// and restores 640 x 480. The line memories are not cleared, since an interior result only
// reads lines and columns written earlier in the same frame.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_inverted import sobel_pkg::*; #(
    parameter int MAX_WIDTH = SOBEL_MAX_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sobel_in_if.sink    i_pix,
    sobel_cfg_if.sink   i_cfg,
    sobel_out_if.source o_res
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          accept;
    logic          in_ready;
    logic [CW-1:0] col;
    t_pix          px;
    t_pos_info     info;
    t_pix          top;
    t_pix          mid;
    logic          wr_en;
    logic [CW-1:0] wr_col;
    t_pix          wr_px;

    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    sobel_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_accept (accept),
        .i_kind   (i_pix.kind),
        .i_pixel  (i_pix.pixel),
        .o_col    (col),
        .o_px     (px),
        .o_info   (info)
    );

    sobel_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_col (col),
        .i_wr_en  (wr_en),
        .i_wr_col (wr_col),
        .i_wr_px  (wr_px),
        .o_mid    (mid),
        .o_top    (top)
    );

    sobel_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_col      (col),
        .i_px       (px),
        .i_info     (info),
        .i_top      (top),
        .i_mid      (mid),
        .o_in_ready (in_ready),
        .o_wr_en    (wr_en),
        .o_wr_col   (wr_col),
        .o_wr_px    (wr_px),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

FILE: src/sobel_chk.sv
// Port-level checks on the edge detector's handshakes, bound to the top level.
// Depends on sobel_pkg and on the top level sobel_edge_magnitude_inverted.
`timescale 1ns / 1ps
`default_nettype none

module sobel_chk import sobel_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_pix i_edge_res,
    input wire logic i_last
);

    // Input backpressure only ever comes from a result that is waiting for its transfer.
    a_stall_needs_full_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready)
    ) else $error("input stalled without a pending result");

    a_out_idle_after_reset: assert property (
        @(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid
    ) else $error("result valid right after reset");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid
    ) else $error("result dropped before its transfer");

    a_out_stable: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_edge_res) && $stable(i_last))
    ) else $error("result payload changed while stalled");

endmodule

bind sobel_edge_magnitude_inverted sobel_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_edge_res  (o_res.edge_res),
    .i_last      (o_res.last_of_frame)
);

`default_nettype wire
